/* rtl/mpd_pkg.sv */
package mpd_pkg;

  localparam int unsigned MaxBlockBytesDefault = 65535;

  localparam int unsigned LcidW   = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned FlagBit = 6;

  localparam logic [LcidW-1:0] PaddingLcidReset = 6'h3F;
  localparam logic [LcidW-1:0] BsrLcidReset     = 6'h3D;

  typedef enum logic [2:0] {
    PH_STOPPED,
    PH_HEADER,
    PH_BSR_SKIP,
    PH_LEN_HIGH,
    PH_LEN_LOW,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD,
    KIND_EMPTY,
    KIND_ERROR
  } kind_t;

  typedef enum logic {
    CFG_PADDING_LCID,
    CFG_BSR_LCID
  } cfg_idx_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [LcidW-1:0] channel_id;
    logic [ByteW-1:0] payload_byte;
    logic             sdu_first;
    logic             sdu_last;
  } result_t;

  typedef struct packed {
    phase_t phase;
  } status_t;

endpackage

/* rtl/mpd_parser.sv */
module mpd_parser #(
  parameter int unsigned MAX_BLOCK_BYTES = mpd_pkg::MaxBlockBytesDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        block_start,
  input  logic [mpd_pkg::LenW-1:0]    block_length,
  input  logic [mpd_pkg::ByteW-1:0]   tb_byte,
  input  logic [mpd_pkg::LcidW-1:0]   padding_lcid,
  input  logic [mpd_pkg::LcidW-1:0]   bsr_lcid,
  output mpd_pkg::result_t            result,
  output mpd_pkg::status_t            status
);

  localparam int unsigned CntW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned CmpW = (CntW > mpd_pkg::LenW) ? CntW : mpd_pkg::LenW;

  mpd_pkg::phase_t              phase_r, phase_nxt;
  logic [CntW-1:0]              blk_left_r, blk_left_nxt;
  logic [mpd_pkg::LenW-1:0]     sdu_left_r, sdu_left_nxt;
  logic [mpd_pkg::LcidW-1:0]    chan_r, chan_nxt;
  logic [mpd_pkg::ByteW-1:0]    len_hi_r, len_hi_nxt;
  logic                         in_prog_r, in_prog_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mpd_pkg::PH_STOPPED;
      blk_left_r <= '0;
      sdu_left_r <= '0;
      chan_r     <= '0;
      len_hi_r   <= '0;
      in_prog_r  <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      blk_left_r <= blk_left_nxt;
      sdu_left_r <= sdu_left_nxt;
      chan_r     <= chan_nxt;
      len_hi_r   <= len_hi_nxt;
      in_prog_r  <= in_prog_nxt;
    end
  end

  always_comb begin
    logic [mpd_pkg::LcidW-1:0] lcid;
    logic [mpd_pkg::LenW-1:0]  sdu_len;
    logic [CntW-1:0]           blk_cur;
    mpd_pkg::phase_t           ph_cur;

    phase_nxt    = phase_r;
    blk_left_nxt = blk_left_r;
    sdu_left_nxt = sdu_left_r;
    chan_nxt     = chan_r;
    len_hi_nxt   = len_hi_r;
    in_prog_nxt  = in_prog_r;
    ph_cur       = phase_r;
    blk_cur      = blk_left_r;
    lcid         = tb_byte[mpd_pkg::LcidW-1:0];
    sdu_len      = {len_hi_r, tb_byte};

    result              = '0;
    result.kind         = mpd_pkg::KIND_PAYLOAD;
    result.channel_id   = chan_r;

    if (block_start) begin
      if (32'(block_length) > 32'(MAX_BLOCK_BYTES)) begin
        blk_cur = CntW'(MAX_BLOCK_BYTES);
      end else begin
        blk_cur = CntW'(block_length);
      end
      ph_cur       = mpd_pkg::PH_HEADER;
      sdu_left_nxt = '0;
      in_prog_nxt  = 1'b0;
      len_hi_nxt   = '0;
    end

    if (blk_cur == '0) begin
      phase_nxt    = mpd_pkg::PH_STOPPED;
      blk_left_nxt = '0;
    end else begin
      blk_left_nxt = blk_cur - CntW'(1);
      phase_nxt    = ph_cur;
      unique case (ph_cur)
        mpd_pkg::PH_HEADER: begin
          if (lcid == padding_lcid) begin
            phase_nxt = mpd_pkg::PH_STOPPED;
          end else if (lcid == bsr_lcid) begin
            phase_nxt = (blk_left_nxt != '0) ? mpd_pkg::PH_BSR_SKIP : mpd_pkg::PH_STOPPED;
          end else begin
            chan_nxt = lcid;
            if (tb_byte[mpd_pkg::FlagBit]) begin
              phase_nxt = (CmpW'(blk_left_nxt) >= CmpW'(2)) ?
                          mpd_pkg::PH_LEN_HIGH : mpd_pkg::PH_STOPPED;
            end else begin
              len_hi_nxt = '0;
              phase_nxt  = (blk_left_nxt != '0) ? mpd_pkg::PH_LEN_LOW : mpd_pkg::PH_STOPPED;
            end
          end
        end
        mpd_pkg::PH_BSR_SKIP: begin
          phase_nxt = mpd_pkg::PH_HEADER;
        end
        mpd_pkg::PH_LEN_HIGH: begin
          len_hi_nxt = tb_byte;
          phase_nxt  = mpd_pkg::PH_LEN_LOW;
        end
        mpd_pkg::PH_LEN_LOW: begin
          len_hi_nxt = '0;
          if (CmpW'(sdu_len) > CmpW'(blk_left_nxt)) begin
            phase_nxt    = mpd_pkg::PH_STOPPED;
            result.valid = 1'b1;
            result.kind  = mpd_pkg::KIND_ERROR;
          end else if (sdu_len == '0) begin
            phase_nxt        = mpd_pkg::PH_HEADER;
            result.valid     = 1'b1;
            result.kind      = mpd_pkg::KIND_EMPTY;
            result.sdu_first = 1'b1;
            result.sdu_last  = 1'b1;
          end else begin
            sdu_left_nxt = sdu_len;
            in_prog_nxt  = 1'b0;
            phase_nxt    = mpd_pkg::PH_PAYLOAD;
          end
        end
        mpd_pkg::PH_PAYLOAD: begin
          result.valid        = 1'b1;
          result.kind         = mpd_pkg::KIND_PAYLOAD;
          result.payload_byte = tb_byte;
          result.sdu_first    = !in_prog_r;
          result.sdu_last     = (sdu_left_r <= mpd_pkg::LenW'(1));
          sdu_left_nxt        = (sdu_left_r != '0) ? sdu_left_r - mpd_pkg::LenW'(1) : '0;
          in_prog_nxt         = 1'b1;
          if (sdu_left_nxt == '0) begin
            in_prog_nxt = 1'b0;
            phase_nxt   = mpd_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = mpd_pkg::PH_STOPPED;
        end
      endcase
    end
  end

  assign status.phase = phase_r;

endmodule

/* rtl/mpd_out_reg.sv */
module mpd_out_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  mpd_pkg::result_t          result,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      in_ready,
  output mpd_pkg::result_t          held
);

  logic             valid_r;
  mpd_pkg::result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= result.valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      data_r <= result;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = data_r;

endmodule

/* rtl/mac_pdu_demultiplexer_with_lcid.sv */
// an accepted byte's result is registered in the output register and shown from the next cycle
// throughput: one byte per cycle while out_ready is high; all parsing is one
//   registered pass of phase update and counter decrement
// reset: synchronous active-low rst_n clears the parser to stopped, zeroes its
//   counters, empties the output register and restores the lcid registers
module mac_pdu_demultiplexer_with_lcid #(
  parameter int unsigned MAX_BLOCK_BYTES = mpd_pkg::MaxBlockBytesDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_block_start,
  input  logic [mpd_pkg::LenW-1:0]    in_block_length,
  input  logic [mpd_pkg::ByteW-1:0]   in_tb_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mpd_pkg::KindW-1:0]   out_kind,
  output logic [mpd_pkg::LcidW-1:0]   out_channel_id,
  output logic [mpd_pkg::ByteW-1:0]   out_payload_byte,
  output logic                        out_sdu_first,
  output logic                        out_sdu_last,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mpd_pkg::LcidW-1:0]   cfg_wdata
);

  logic [mpd_pkg::LcidW-1:0] pad_lcid_r;
  logic [mpd_pkg::LcidW-1:0] bsr_lcid_r;
  logic                      accept;
  mpd_pkg::result_t          result;
  mpd_pkg::result_t          held;
  mpd_pkg::status_t          status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_lcid_r <= mpd_pkg::PaddingLcidReset;
      bsr_lcid_r <= mpd_pkg::BsrLcidReset;
    end else if (cfg_we) begin
      unique case (mpd_pkg::cfg_idx_t'(cfg_index))
        mpd_pkg::CFG_PADDING_LCID: pad_lcid_r <= cfg_wdata;
        mpd_pkg::CFG_BSR_LCID:     bsr_lcid_r <= cfg_wdata;
        default:                   pad_lcid_r <= pad_lcid_r;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  mpd_parser #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .block_start  (in_block_start),
    .block_length (in_block_length),
    .tb_byte      (in_tb_byte),
    .padding_lcid (pad_lcid_r),
    .bsr_lcid     (bsr_lcid_r),
    .result       (result),
    .status       (status)
  );

  mpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .in_ready  (in_ready),
    .held      (held)
  );

  assign out_kind         = held.kind;
  assign out_channel_id   = held.channel_id;
  assign out_payload_byte = held.payload_byte;
  assign out_sdu_first    = held.sdu_first;
  assign out_sdu_last     = held.sdu_last;

  a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == mpd_pkg::KIND_EMPTY) |-> (out_sdu_first && out_sdu_last))
    else $error("empty sdu marker without first and last marks");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == mpd_pkg::KIND_ERROR) |->
      (!out_sdu_first && !out_sdu_last && out_payload_byte == '0))
    else $error("overrun error carries marks or data");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && result.valid && result.kind == mpd_pkg::KIND_ERROR) |=>
      (status.phase == mpd_pkg::PH_STOPPED))
    else $error("parser kept running after an overrun");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output register not emptied by reset");

endmodule
